[src/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/ffsa_pkg.sv]
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int HEADER_BYTES = 40;
    localparam int ADDR_BITS    = 20;
    localparam int CFG_W        = 21;
    localparam int IDX_W        = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    // wide enough for the config value and for 2^ADDR_BITS
    localparam int HW           = (CFG_W > ADDR_BITS + 1) ? CFG_W : ADDR_BITS + 1;

    localparam longint HEAP_MIN   = 64;
    localparam longint HEAP_MAX   = longint'(1) << ADDR_BITS;
    localparam longint RESET_HEAP = 65536;

    localparam logic [ADDR_BITS-1:0] HDR = ADDR_BITS'(HEADER_BYTES);
    localparam logic [ADDR_BITS-1:0] RESET_LEN =
        (RESET_HEAP > HEADER_BYTES) ? ADDR_BITS'(RESET_HEAP - HEADER_BYTES) : '0;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic MODE_ALLOC = 1'b0;

    typedef struct packed {
        logic                 mode;
        logic [ADDR_BITS-1:0] request_bytes;
        logic [ADDR_BITS-1:0] release_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           status;
        logic [ADDR_BITS-1:0] address;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0] offset;
        logic [ADDR_BITS-1:0] length;
        logic                 is_free;
    } t_seg;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_SPLIT = 3'd2,
        OP_TAKE  = 3'd3,
        OP_FREE  = 3'd4,
        OP_MERGE = 3'd5
    } t_op;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_op                  op;
        logic [IDX_W-1:0]     pos;
        logic [ADDR_BITS-1:0] bytes;
        logic [ADDR_BITS-1:0] load_len;
    } t_cell_cmd;

endpackage

[src/ffsa_cell.sv]
module ffsa_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ffsa_pkg::IDX_W-1:0]  i_idx,
    input  ffsa_pkg::t_cell_cmd         i_cmd,
    input  ffsa_pkg::t_seg              i_left,
    input  ffsa_pkg::t_seg              i_right,
    output ffsa_pkg::t_seg              o_seg
);

    ffsa_pkg::t_seg r_seg, n_seg;
    logic [ffsa_pkg::IDX_W:0] w_idx, w_pos1;

    assign w_idx  = {1'b0, i_idx};
    assign w_pos1 = {1'b0, i_cmd.pos} + (ffsa_pkg::IDX_W+1)'(1);

    // next segment value: own update or neighbor hand-over
    always_comb begin
        n_seg = r_seg;
        case (i_cmd.op)
            ffsa_pkg::OP_LOAD: begin
                if (i_idx == '0) begin
                    n_seg.offset  = ffsa_pkg::HDR;
                    n_seg.length  = i_cmd.load_len;
                    n_seg.is_free = 1'b1;
                end else begin
                    n_seg = '0;
                end
            end
            ffsa_pkg::OP_SPLIT: begin
                if (i_idx == i_cmd.pos) begin
                    n_seg.length  = i_cmd.bytes;
                    n_seg.is_free = 1'b0;
                end else if (w_idx == w_pos1) begin
                    n_seg.offset  = i_left.offset + i_cmd.bytes + ffsa_pkg::HDR;
                    n_seg.length  = i_left.length - i_cmd.bytes - ffsa_pkg::HDR;
                    n_seg.is_free = 1'b1;
                end else if (w_idx > w_pos1) begin
                    n_seg = i_left;
                end
            end
            ffsa_pkg::OP_TAKE: begin
                if (i_idx == i_cmd.pos) n_seg.is_free = 1'b0;
            end
            ffsa_pkg::OP_FREE: begin
                if (i_idx == i_cmd.pos) n_seg.is_free = 1'b1;
            end
            ffsa_pkg::OP_MERGE: begin
                if (i_idx == i_cmd.pos) begin
                    n_seg.length = r_seg.length + ffsa_pkg::HDR + i_right.length;
                end else if (i_idx > i_cmd.pos) begin
                    n_seg = i_right;
                end
            end
            default: n_seg = r_seg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            if (i_idx == '0) begin
                r_seg.offset  <= ffsa_pkg::HDR;
                r_seg.length  <= ffsa_pkg::RESET_LEN;
                r_seg.is_free <= 1'b1;
            end else begin
                r_seg <= '0;
            end
        end else begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

[src/first_fit_segment_allocator_unit.sv]
// First-fit heap allocator over a chain of MAX_SEGMENTS segment cells. One
// request at a time: an allocate walks the chain one cell per cycle until it
// finds a fit or passes the last used cell; a release walks for the matching
// offset and then runs a merge pass that visits the cells in order and merges
// each pair of free neighbours. Splits and merges shift the chain by one cell,
// all cells updating together. The result sits in an output register, so a
// new request is taken while it waits. A heap_size write rebuilds the table.
`include "assert_macros.svh"

module first_fit_segment_allocator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ffsa_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ffsa_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ffsa_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int AW = ffsa_pkg::ADDR_BITS;
    localparam int CW = ffsa_pkg::CNT_W;
    localparam int IW = ffsa_pkg::IDX_W;
    localparam int N  = ffsa_pkg::MAX_SEGMENTS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ASCAN = 5'b00010,
        S_RSCAN = 5'b00100,
        S_MERGE = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [2:0]            r_st, n_st;
    logic [AW-1:0]         r_addr, n_addr;
    ffsa_pkg::t_in_item    r_req, n_req;
    logic                  r_ovld, n_ovld;
    ffsa_pkg::t_out_item   r_odata, n_odata;

    ffsa_pkg::t_cell_cmd   cmd;
    ffsa_pkg::t_seg        segs [N];
    ffsa_pkg::t_seg        cur, nxt;
    logic [CW-1:0]         pos1;
    logic                  in_xfer, cfg_xfer, out_free;
    logic [ffsa_pkg::HW-1:0] heap;
    logic [AW:0]           need;

    // chain of cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        ffsa_pkg::t_seg left_seg, right_seg;
        if (g == 0) begin : g_first
            assign left_seg = '0;
        end else begin : g_mid_l
            assign left_seg = segs[g-1];
        end
        if (g == N - 1) begin : g_last
            assign right_seg = '0;
        end else begin : g_mid_r
            assign right_seg = segs[g+1];
        end
        ffsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IW'(g)),
            .i_cmd   (cmd),
            .i_left  (left_seg),
            .i_right (right_seg),
            .o_seg   (segs[g])
        );
    end

    // handshakes
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_ovld || !i_out_stall;

    // cell reads for the scan
    assign pos1 = r_pos + CW'(1);
    assign cur  = segs[r_pos[IW-1:0]];
    assign nxt  = segs[pos1[IW-1:0]];
    assign need = {1'b0, r_req.request_bytes} + (AW+1)'(ffsa_pkg::HEADER_BYTES);

    // saturated heap size from a config write
    always_comb begin
        heap = ffsa_pkg::HW'(i_cfg_data);
        if (heap < ffsa_pkg::HW'(ffsa_pkg::HEAP_MIN)) heap = ffsa_pkg::HW'(ffsa_pkg::HEAP_MIN);
        if (heap > ffsa_pkg::HW'(ffsa_pkg::HEAP_MAX)) heap = ffsa_pkg::HW'(ffsa_pkg::HEAP_MAX);
    end

    // control
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_st         = r_st;
        n_addr       = r_addr;
        n_req        = r_req;
        n_ovld       = r_ovld && i_out_stall;
        n_odata      = r_odata;
        cmd.op       = ffsa_pkg::OP_NONE;
        cmd.pos      = r_pos[IW-1:0];
        cmd.bytes    = r_req.request_bytes;
        cmd.load_len = (heap > ffsa_pkg::HW'(ffsa_pkg::HEADER_BYTES))
                     ? AW'(heap - ffsa_pkg::HW'(ffsa_pkg::HEADER_BYTES)) : '0;
        case (r_state)
            S_IDLE: begin
                if (cfg_xfer) begin
                    cmd.op = ffsa_pkg::OP_LOAD;
                    n_cnt  = CW'(1);
                end else if (in_xfer) begin
                    n_req  = i_in_data;
                    n_pos  = '0;
                    n_addr = '0;
                    if (i_in_data.mode != ffsa_pkg::MODE_ALLOC) begin
                        n_state = S_RSCAN;
                    end else if (i_in_data.request_bytes == '0) begin
                        n_st    = ffsa_pkg::ST_BAD_SIZE;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_ASCAN;
                    end
                end
            end
            S_ASCAN: begin
                if (r_pos >= r_cnt) begin
                    n_st    = ffsa_pkg::ST_NO_FIT;
                    n_state = S_OUT;
                end else if (cur.is_free && ({1'b0, cur.length} > need)) begin
                    n_state = S_OUT;
                    if (r_cnt == CW'(N)) begin
                        n_st = ffsa_pkg::ST_FULL;
                    end else begin
                        cmd.op = ffsa_pkg::OP_SPLIT;
                        n_cnt  = r_cnt + CW'(1);
                        n_st   = ffsa_pkg::ST_OK;
                        n_addr = cur.offset;
                    end
                end else if (cur.is_free && (cur.length == r_req.request_bytes)) begin
                    cmd.op  = ffsa_pkg::OP_TAKE;
                    n_st    = ffsa_pkg::ST_OK;
                    n_addr  = cur.offset;
                    n_state = S_OUT;
                end else begin
                    n_pos = pos1;
                end
            end
            S_RSCAN: begin
                if (r_pos >= r_cnt) begin
                    n_st    = ffsa_pkg::ST_NOT_FOUND;
                    n_pos   = '0;
                    n_state = S_MERGE;
                end else if (cur.offset == r_req.release_address) begin
                    cmd.op  = ffsa_pkg::OP_FREE;
                    n_st    = ffsa_pkg::ST_OK;
                    n_pos   = '0;
                    n_state = S_MERGE;
                end else begin
                    n_pos = pos1;
                end
            end
            S_MERGE: begin
                if (pos1 >= r_cnt) begin
                    n_state = S_OUT;
                end else if (cur.is_free && nxt.is_free) begin
                    cmd.op = ffsa_pkg::OP_MERGE;
                    n_cnt  = r_cnt - CW'(1);
                end else begin
                    n_pos = pos1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovld          = 1'b1;
                    n_odata.status  = r_st;
                    n_odata.address = r_addr;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= CW'(1);
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_st    <= n_st;
        r_addr  <= n_addr;
        r_req   <= n_req;
        r_odata <= n_odata;
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, (r_cnt != '0) && (r_cnt <= CW'(N)))
    `ASSERT_IMPL(a_addr_only_ok, i_clk, i_rst_n, o_out_valid && (o_out_data.address != '0), o_out_data.status == ffsa_pkg::ST_OK)
    `ASSERT_NEXT(a_split_grows, i_clk, i_rst_n, cmd.op == ffsa_pkg::OP_SPLIT, r_cnt == $past(r_cnt) + CW'(1))
    `ASSERT_NEXT(a_merge_shrinks, i_clk, i_rst_n, cmd.op == ffsa_pkg::OP_MERGE, r_cnt == $past(r_cnt) - CW'(1))

endmodule
